// File: rtl/ndm_pkg.sv
// ----------------------------------------------------------------------------
// ndm_pkg
// Shared constants, field layout and controller/datapath interface types of
// the nearest descriptor match unit.
// ----------------------------------------------------------------------------
package ndm_pkg;

  // default sizes
  localparam int DESC_LEN_DEF    = 32;
  localparam int MAX_TARGETS_DEF = 1024;

  // item field widths
  localparam int KIND_W    = 1;
  localparam int ENTRY_W   = 10;
  localparam int ELEMENT_W = 5;
  localparam int VALUE_W   = 16;
  localparam int TCOUNT_W  = 11;
  localparam int QNUM_W    = 16;
  localparam int MIDX_W    = 10;
  localparam int DIST_W    = 37;

  // input tdata layout, lowest bit first: entry, element, value
  localparam int ENTRY_LSB    = 0;
  localparam int ELEMENT_LSB  = ENTRY_LSB + ENTRY_W;
  localparam int VALUE_LSB    = ELEMENT_LSB + ELEMENT_W;
  localparam int S_TDATA_W    = 32;

  // output tdata layout, lowest bit first: query_number, match_index,
  // best_distance_sq
  localparam int QNUM_LSB     = 0;
  localparam int MIDX_LSB     = QNUM_LSB + QNUM_W;
  localparam int DIST_LSB     = MIDX_LSB + MIDX_W;
  localparam int M_TDATA_W    = 64;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // absolute difference is at most 16 bits, its square 32 bits
  localparam int SQ_W = 32;

  // item kind codes
  localparam logic [KIND_W-1:0] KIND_TARGET = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic start;   // clear the running best for a new scan
    logic issue;   // read the target at scan_addr
    logic emit;    // load the result register
  } ndm_cmd_t;

  typedef struct packed {
    logic final_query;  // current input completes a query
    logic busy;         // distances still in flight
    logic out_free;     // result register can take a new result
  } ndm_sts_t;

endpackage

// File: rtl/ndm_ram.sv
// ----------------------------------------------------------------------------
// ndm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ndm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/ndm_ctrl.sv
// ----------------------------------------------------------------------------
// ndm_ctrl
// Sequencer: takes input transactions, walks the loaded targets during a
// scan, waits for the distance pipeline to drain and hands off the result.
// ----------------------------------------------------------------------------
module ndm_ctrl #(
  parameter int MAX_TARGETS = ndm_pkg::MAX_TARGETS_DEF,
  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
  localparam int CNT_W = $clog2(MAX_TARGETS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic                          cfg_wr_en,
  input  logic [ndm_pkg::TCOUNT_W-1:0]  cfg_wr_data,
  input  ndm_pkg::ndm_sts_t             sts,
  output ndm_pkg::ndm_cmd_t             cmd,
  output logic [IDX_W-1:0]              scan_addr
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                       state, state_next;
  logic [ndm_pkg::TCOUNT_W-1:0] target_count;
  logic [CNT_W-1:0]             scan_len;
  logic [CNT_W-1:0]             cnt, cnt_next;

  // saturate the searched count at the store size
  always_comb begin
    if (32'(target_count) > 32'(MAX_TARGETS)) begin
      scan_len = CNT_W'(MAX_TARGETS);
    end else begin
      scan_len = CNT_W'(target_count);
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign scan_addr = cnt[IDX_W-1:0];

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid && sts.final_query) begin
          cmd.start = 1'b1;
          cnt_next  = '0;
          state_next = (scan_len == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        cnt_next  = CNT_W'(cnt + 1'b1);
        if (CNT_W'(cnt + 1'b1) == scan_len) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy && sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      target_count <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) begin
        target_count <= cfg_wr_data;
      end
    end
  end

endmodule

// File: rtl/ndm_datapath.sv
// ----------------------------------------------------------------------------
// ndm_datapath
// Target store (one RAM bank per element), query buffer, parallel squared
// differences, registered adder tree, running minimum and result register.
// ----------------------------------------------------------------------------
module ndm_datapath #(
  parameter int DESC_LEN    = ndm_pkg::DESC_LEN_DEF,
  parameter int MAX_TARGETS = ndm_pkg::MAX_TARGETS_DEF,
  localparam int IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
  localparam int LVL    = $clog2(DESC_LEN),
  localparam int LEAVES = 1 << LVL,
  localparam int SUM_W  = ndm_pkg::SQ_W + LVL,
  localparam int PIPE   = LVL + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ndm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [ndm_pkg::KIND_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ndm_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tuser,
  input  ndm_pkg::ndm_cmd_t              cmd,
  input  logic [IDX_W-1:0]               scan_addr,
  output ndm_pkg::ndm_sts_t              sts
);

  logic [ndm_pkg::ENTRY_W-1:0]   in_entry;
  logic [ndm_pkg::ELEMENT_W-1:0] in_element;
  logic [ndm_pkg::VALUE_W-1:0]   in_value;
  logic                          entry_ok;

  logic [ndm_pkg::VALUE_W-1:0] qbuf   [DESC_LEN];
  logic [ndm_pkg::VALUE_W-1:0] tgt_rd [DESC_LEN];
  logic [ndm_pkg::SQ_W-1:0]    sq     [DESC_LEN];
  logic [SUM_W-1:0]            tree   [LVL+1][LEAVES];

  logic [PIPE-1:0]  vpipe;
  logic [IDX_W-1:0] ipipe [PIPE];

  logic [ndm_pkg::DIST_W-1:0] dist_sat;
  logic [ndm_pkg::DIST_W-1:0] best;
  logic [IDX_W-1:0]           best_idx;
  logic                       have;
  logic [ndm_pkg::QNUM_W-1:0] query_count;

  logic [ndm_pkg::QNUM_W-1:0] out_qnum;
  logic [ndm_pkg::MIDX_W-1:0] out_midx;
  logic [ndm_pkg::DIST_W-1:0] out_dist;
  logic                       out_found;

  assign in_entry   = s_tdata[ndm_pkg::ENTRY_LSB   +: ndm_pkg::ENTRY_W];
  assign in_element = s_tdata[ndm_pkg::ELEMENT_LSB +: ndm_pkg::ELEMENT_W];
  assign in_value   = s_tdata[ndm_pkg::VALUE_LSB   +: ndm_pkg::VALUE_W];
  assign entry_ok   = 32'(in_entry) < MAX_TARGETS;

  assign sts.final_query = (s_tuser == ndm_pkg::KIND_QUERY) &&
                           (32'(in_element) == DESC_LEN - 1);
  assign sts.busy        = |vpipe;
  assign sts.out_free    = !m_tvalid || m_tready;

  // one bank and one lane per descriptor element
  for (genvar g = 0; g < DESC_LEN; g++) begin : g_lane
    logic                         bank_we;
    logic signed [ndm_pkg::VALUE_W:0] diff;
    logic [ndm_pkg::VALUE_W-1:0]  adiff;

    assign bank_we = cmd.accept && (s_tuser == ndm_pkg::KIND_TARGET) && entry_ok &&
                     (32'(in_element) == g);

    ndm_ram #(
      .WIDTH (ndm_pkg::VALUE_W),
      .DEPTH (MAX_TARGETS)
    ) u_bank (
      .clk     (clk),
      .wr_en   (bank_we),
      .wr_addr (IDX_W'(in_entry)),
      .wr_data (in_value),
      .rd_addr (scan_addr),
      .rd_data (tgt_rd[g])
    );

    always_ff @(posedge clk) begin
      if (cmd.accept && (s_tuser == ndm_pkg::KIND_QUERY) && (32'(in_element) == g)) begin
        qbuf[g] <= in_value;
      end
    end

    always_comb begin
      diff  = $signed({qbuf[g][ndm_pkg::VALUE_W-1], qbuf[g]}) -
              $signed({tgt_rd[g][ndm_pkg::VALUE_W-1], tgt_rd[g]});
      adiff = diff[ndm_pkg::VALUE_W] ? ndm_pkg::VALUE_W'(-diff)
                                     : diff[ndm_pkg::VALUE_W-1:0];
      sq[g] = ndm_pkg::SQ_W'(adiff * adiff);
    end
  end

  // leaves of the adder tree, zero padded to a power of two
  for (genvar n = 0; n < LEAVES; n++) begin : g_leaf
    always_ff @(posedge clk) begin
      if (n < DESC_LEN) begin
        tree[0][n] <= SUM_W'(sq[n < DESC_LEN ? n : 0]);
      end else begin
        tree[0][n] <= '0;
      end
    end
  end

  for (genvar l = 1; l <= LVL; l++) begin : g_level
    for (genvar n = 0; n < (LEAVES >> l); n++) begin : g_node
      always_ff @(posedge clk) begin
        tree[l][n] <= tree[l-1][2*n] + tree[l-1][2*n+1];
      end
    end
  end

  always_comb begin
    if (64'(tree[LVL][0]) > 64'(ndm_pkg::DIST_MAX)) begin
      dist_sat = ndm_pkg::DIST_MAX;
    end else begin
      dist_sat = ndm_pkg::DIST_W'(tree[LVL][0]);
    end
  end

  // carry the target index alongside its distance
  always_ff @(posedge clk) begin
    ipipe[0] <= scan_addr;
    for (int i = 1; i < PIPE; i++) begin
      ipipe[i] <= ipipe[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe       <= '0;
      have        <= 1'b0;
      m_tvalid    <= 1'b0;
      query_count <= '0;
    end else begin
      vpipe <= {vpipe[PIPE-2:0], cmd.issue};
      if (cmd.start) begin
        have <= 1'b0;
      end else if (vpipe[PIPE-1] && (!have || dist_sat < best)) begin
        have <= 1'b1;
      end
      if (cmd.emit) begin
        m_tvalid    <= 1'b1;
        query_count <= ndm_pkg::QNUM_W'(query_count + 1'b1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // strictly smaller wins, so the lowest index keeps a tie
  always_ff @(posedge clk) begin
    if (vpipe[PIPE-1] && (!have || dist_sat < best)) begin
      best     <= dist_sat;
      best_idx <= ipipe[PIPE-1];
    end
    if (cmd.emit) begin
      out_qnum  <= query_count;
      out_found <= have;
      out_midx  <= have ? ndm_pkg::MIDX_W'(best_idx) : '0;
      out_dist  <= have ? best : '0;
    end
  end

  assign m_tdata = ndm_pkg::M_TDATA_W'({out_dist, out_midx, out_qnum});
  assign m_tuser = out_found;

endmodule

// File: rtl/nearest_descriptor_match_unit.sv
// Load and non-final query transactions: one per cycle, no result.
// Final query element: the result follows a scan of N searched targets, one target
// distance per cycle through bank read, squaring stage and registered adder tree,
// and the drain of that pipeline; the scan is skipped when N is 0.
// No new input is taken until the result is handed off. Reset (rst, synchronous)
// clears control, count register and query number; stores are undefined until written.
// ----------------------------------------------------------------------------
// nearest_descriptor_match_unit
// Brute-force nearest neighbor search with squared L2 distance over
// fixed-length descriptors.
// ----------------------------------------------------------------------------
module nearest_descriptor_match_unit #(
  parameter int DESC_LEN    = ndm_pkg::DESC_LEN_DEF,
  parameter int MAX_TARGETS = ndm_pkg::MAX_TARGETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ndm_pkg::S_TDATA_W-1:0]  s_tdata,   // entry, element, value, zero pad
  input  logic [ndm_pkg::KIND_W-1:0]     s_tuser,   // kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ndm_pkg::M_TDATA_W-1:0]  m_tdata,   // query_number, match_index,
                                                    // best_distance_sq, zero pad
  output logic                           m_tuser,   // found
  input  logic                           cfg_wr_en,
  input  logic [ndm_pkg::TCOUNT_W-1:0]   cfg_wr_data  // target_count
);

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

  ndm_pkg::ndm_cmd_t cmd;
  ndm_pkg::ndm_sts_t sts;
  logic [IDX_W-1:0]  scan_addr;

  ndm_ctrl #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sts         (sts),
    .cmd         (cmd),
    .scan_addr   (scan_addr)
  );

  ndm_datapath #(
    .DESC_LEN    (DESC_LEN),
    .MAX_TARGETS (MAX_TARGETS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .sts       (sts)
  );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_descriptor_match_unit. A stimulus table
// covers the empty search, the largest distance, exact hits and a tie. A
// random part follows with near-copy queries, partial query updates and
// target loads under several small target counts, with idle and stall
// patterns on both streams. Each result is checked field by field against its
// table row or an in-bench search model fed from the accepted transactions.
// ----------------------------------------------------------------------------
module tb_top;
  import ndm_pkg::*;

  localparam int LAST_EL     = DESC_LEN_DEF - 1;
  localparam int CFG_SETTLE  = 16;
  localparam int END_DRAIN   = 40;
  localparam int RX_HOLD     = 400;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SET_ITEMS   = 25;

  typedef struct packed {
    logic [QNUM_W-1:0] qnum;
    logic [MIDX_W-1:0] midx;
    logic              found;
    logic [DIST_W-1:0] dist_sq;
  } match_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ENTRY_W-1:0]   entry;
    logic [ELEMENT_W-1:0] element;
    logic [VALUE_W-1:0]   value;
    logic                 typed;  // use the match below instead of the model
    match_t               want;
  } desc_item_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FILL_T, ROW_FILL_Q} row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [KIND_W-1:0]    kind;
    logic [ENTRY_W-1:0]   entry;
    logic [ELEMENT_W-1:0] element;
    logic [VALUE_W-1:0]   value;
    logic [TCOUNT_W-1:0]  count;
    logic                 typed;
    match_t               want;
  } row_t;

  localparam int N_ROWS = 16;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    // no targets right after reset
    '{ROW_ITEM, KIND_QUERY, 10'd0, 5'd31, 16'h0000, 11'd0, 1'b1,
      '{16'd0, 10'd0, 1'b0, 37'd0}},
    '{ROW_CFG, KIND_TARGET, 10'd0, 5'd0, 16'h0000, 11'd1, 1'b0, '0},
    '{ROW_FILL_T, KIND_TARGET, 10'd0, 5'd0, 16'h8000, 11'd0, 1'b0, '0},
    // every element at opposite extremes: largest possible distance
    '{ROW_FILL_Q, KIND_QUERY, 10'd0, 5'd0, 16'h7fff, 11'd0, 1'b1,
      '{16'd1, 10'd0, 1'b1, 37'd137434759200}},
    '{ROW_FILL_T, KIND_TARGET, 10'd1, 5'd0, 16'h7fff, 11'd0, 1'b0, '0},
    '{ROW_CFG, KIND_TARGET, 10'd0, 5'd0, 16'h0000, 11'd2, 1'b0, '0},
    '{ROW_ITEM, KIND_QUERY, 10'd1023, 5'd31, 16'h7fff, 11'd0, 1'b1,
      '{16'd2, 10'd1, 1'b1, 37'd0}},
    '{ROW_FILL_T, KIND_TARGET, 10'd2, 5'd0, 16'h7fff, 11'd0, 1'b0, '0},
    '{ROW_CFG, KIND_TARGET, 10'd0, 5'd0, 16'h0000, 11'd3, 1'b0, '0},
    // targets 1 and 2 tie at zero: lower index wins
    '{ROW_ITEM, KIND_QUERY, 10'd512, 5'd31, 16'h7fff, 11'd0, 1'b1,
      '{16'd3, 10'd1, 1'b1, 37'd0}},
    '{ROW_ITEM, KIND_QUERY, 10'd0, 5'd0, 16'h8000, 11'd0, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, 10'd1023, 5'd31, 16'h0000, 11'd0, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, 10'd2, 5'd5, 16'hffff, 11'd0, 1'b0, '0},
    '{ROW_ITEM, KIND_QUERY, 10'd0, 5'd31, 16'hffff, 11'd0, 1'b0, '0},
    '{ROW_CFG, KIND_TARGET, 10'd0, 5'd0, 16'h0000, 11'd0, 1'b0, '0},
    '{ROW_ITEM, KIND_QUERY, 10'd0, 5'd31, 16'h0001, 11'd0, 1'b1,
      '{16'd5, 10'd0, 1'b0, 37'd0}}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // entry, element, value, zero pad
  logic [KIND_W-1:0]     s_tuser = '0;   // kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // query_number, match_index,
                                         // best_distance_sq, zero pad
  logic                  m_tuser;        // found
  logic                  cfg_wr_en = 1'b0;
  logic [TCOUNT_W-1:0]   cfg_wr_data = '0;  // target_count

  // search model state
  logic signed [VALUE_W-1:0] tgt_mem [MAX_TARGETS_DEF][DESC_LEN_DEF];
  logic signed [VALUE_W-1:0] qry_buf [DESC_LEN_DEF];
  logic [QNUM_W-1:0]         qry_seq = '0;
  logic [TCOUNT_W-1:0]       tcount = '0;

  // elements already scheduled for writing, per target
  bit [DESC_LEN_DEF-1:0] tgt_mask [MAX_TARGETS_DEF];

  desc_item_t desc_item_q[$];
  match_t     pending_matches[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int n_in = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_err = 0;

  nearest_descriptor_match_unit dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one accepted transaction; returns 1 when it completes a query.
  function automatic bit predict_match(input desc_item_t it, output match_t res);
    int unsigned lim;
    int t, e, d;
    longint sum, best;
    bit have;
    res = '0;
    if (it.kind == KIND_TARGET) begin
      tgt_mem[it.entry][it.element] = it.value;
      return 1'b0;
    end
    qry_buf[it.element] = it.value;
    if (it.element != LAST_EL) return 1'b0;
    lim = (tcount > MAX_TARGETS_DEF) ? MAX_TARGETS_DEF : tcount;
    have = 1'b0;
    best = 0;
    for (t = 0; t < int'(lim); t++) begin
      sum = 0;
      for (e = 0; e < DESC_LEN_DEF; e++) begin
        d = int'(qry_buf[e]) - int'(tgt_mem[t][e]);
        sum += longint'(d) * longint'(d);
      end
      if (sum > DIST_MAX) sum = DIST_MAX;
      // strict compare keeps the first target on a tie
      if (!have || sum < best) begin
        best = sum;
        res.midx = MIDX_W'(t);
        have = 1'b1;
      end
    end
    res.qnum = qry_seq;
    res.found = have;
    res.dist_sq = have ? best[DIST_W-1:0] : '0;
    qry_seq++;
    return 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_element_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3, 4: return VALUE_W'($urandom_range(0, 6)) - 16'd3;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic void push_item(input logic [KIND_W-1:0] k,
                                    input logic [ENTRY_W-1:0] ent,
                                    input logic [ELEMENT_W-1:0] el,
                                    input logic [VALUE_W-1:0] v,
                                    input logic typed, input match_t want);
    desc_item_t it;
    it.kind = k;
    it.entry = ent;
    it.element = el;
    it.value = v;
    it.typed = typed;
    it.want = want;
    if (k == KIND_TARGET) tgt_mask[ent][el] = 1'b1;
    desc_item_q.insert(desc_item_q.size(), it);
  endfunction

  function automatic void fill_target(input int t, input bit rnd,
                                      input logic [VALUE_W-1:0] v);
    int e;
    for (e = 0; e < DESC_LEN_DEF; e++)
      push_item(KIND_TARGET, ENTRY_W'(t), ELEMENT_W'(e),
                rnd ? pick_element_value() : v, 1'b0, '0);
  endfunction

  // Rewrite a few query elements, then the last one to start a search.
  function automatic void touch_query(input int k);
    int i;
    for (i = 0; i < k; i++)
      push_item(KIND_QUERY, ENTRY_W'($urandom), ELEMENT_W'($urandom_range(0, LAST_EL - 1)),
                pick_element_value(), 1'b0, '0);
    push_item(KIND_QUERY, ENTRY_W'($urandom), ELEMENT_W'(LAST_EL), pick_element_value(),
              1'b0, '0);
  endfunction

  // Full query copied from a stored target, optionally nudged by one step.
  task automatic near_query(input int t, input bit noisy);
    int e;
    logic [VALUE_W-1:0] v;
    while (desc_item_q.size() != 0) @(posedge clk);
    for (e = 0; e < DESC_LEN_DEF; e++) begin
      v = tgt_mem[t][e];
      if (noisy && $urandom_range(0, 1) == 1) v = v + VALUE_W'($urandom_range(0, 2)) - 16'd1;
      push_item(KIND_QUERY, ENTRY_W'($urandom), ELEMENT_W'(e), v, 1'b0, '0);
    end
  endtask

  task automatic set_target_count(input logic [TCOUNT_W-1:0] c);
    while (desc_item_q.size() != 0 || pending_matches.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tcount = c;
    n_cfg++;
  endtask

  task automatic run_setting(input int n_items, input bit squeeze);
    logic [TCOUNT_W-1:0] c;
    logic [ENTRY_W-1:0] ent;
    int pushed, sel, k, i, t, lim;
    sel = $urandom_range(0, 9);
    if (sel == 0) c = '0;
    else if (sel == 1) c = 11'd1;
    else c = TCOUNT_W'($urandom_range(2, 8));
    lim = int'(c);
    // every searched target must be complete before the first search
    for (t = 0; t < lim; t++)
      if (tgt_mask[t] != '1) fill_target(t, 1'b1, '0);
    set_target_count(c);
    pushed = 0;
    if (squeeze) begin
      hold_reqs <= hold_reqs + 1;
      touch_query(1);
      pushed = 2;
    end
    while (pushed < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 15 && lim > 0) begin
        near_query($urandom_range(0, lim - 1), 1'b1);
        pushed += DESC_LEN_DEF;
      end else if (sel < 60) begin
        k = $urandom_range(1, 4);
        touch_query(k);
        pushed += k + 1;
      end else if (sel < 90) begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0) ent = ENTRY_W'($urandom);
          else ent = ENTRY_W'($urandom_range(0, lim + 4));
          push_item(KIND_TARGET, ent, ELEMENT_W'($urandom_range(0, LAST_EL)),
                    pick_element_value(), 1'b0, '0);
        end
        pushed += k;
      end else begin
        // stray query element, sometimes the last one, which starts a search
        push_item(KIND_QUERY, ENTRY_W'($urandom), ELEMENT_W'($urandom_range(0, LAST_EL)),
                  pick_element_value(), 1'b0, '0);
        pushed++;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Offer queued transactions; hold valid and data until accepted.
  always @(posedge clk) begin : item_drive
    desc_item_t it;
    match_t res;
    if (s_tvalid && s_tready) begin
      it = desc_item_q.pop_front();
      n_in++;
      if (predict_match(it, res))
        pending_matches.insert(pending_matches.size(), it.typed ? it.want : res);
    end
    if (!s_tvalid || s_tready) begin
      if (desc_item_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, desc_item_q[0].value, desc_item_q[0].element, desc_item_q[0].entry};
        s_tuser <= desc_item_q[0].kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    match_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_matches.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result, expected none, %s %0d idx %0d found %0b dist %0d",
                 $time, "actual qnum", m_tdata[QNUM_LSB +: QNUM_W],
                 m_tdata[MIDX_LSB +: MIDX_W], m_tuser, m_tdata[DIST_LSB +: DIST_W]);
      end else begin
        want = pending_matches.pop_front();
        check_field("query_number", 64'(want.qnum), 64'(m_tdata[QNUM_LSB +: QNUM_W]));
        check_field("match_index", 64'(want.midx), 64'(m_tdata[MIDX_LSB +: MIDX_W]));
        check_field("found", 64'(want.found), 64'(m_tuser));
        check_field("best_distance_sq", 64'(want.dist_sq), 64'(m_tdata[DIST_LSB +: DIST_W]));
        n_checked++;
      end
    end
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = RX_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    row_t row;
    int i, e;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      case (row.op)
        ROW_ITEM: begin
          push_item(row.kind, row.entry, row.element, row.value, row.typed, row.want);
        end
        ROW_CFG: begin
          set_target_count(row.count);
        end
        ROW_FILL_T: begin
          fill_target(int'(row.entry), 1'b0, row.value);
        end
        ROW_FILL_Q: begin
          for (e = 0; e < DESC_LEN_DEF; e++)
            push_item(KIND_QUERY, row.entry, ELEMENT_W'(e), row.value,
                      (e == LAST_EL) ? row.typed : 1'b0, row.want);
        end
        default: begin
        end
      endcase
    end

    tx_idle_pct = 22;
    rx_idle_pct = 65;
    for (i = 0; i < 3; i++) run_setting(SET_ITEMS, 1'b0);
    tx_idle_pct = 65;
    rx_idle_pct = 22;
    for (i = 0; i < 3; i++) run_setting(SET_ITEMS, 1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_setting(SET_ITEMS, 1'b1);
    for (i = 0; i < 2; i++) run_setting(SET_ITEMS, 1'b0);

    while (desc_item_q.size() != 0 || pending_matches.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("tb_top: %0d descriptor transactions accepted, %0d match results checked",
             n_in, n_checked);
    $display("tb_top: %0d target_count writes, idle and long stall phases on both streams",
             n_cfg);
    if (n_err == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ndm_pkg.sv
rtl/ndm_ram.sv
rtl/ndm_ctrl.sv
rtl/ndm_datapath.sv
rtl/nearest_descriptor_match_unit.sv
sim/tb_top.sv
